FILE: rtl/core/gmdw_pkg.sv
// Shared types and constants for the grid maze depth-first walker.
// Used by gmdw_ctrl, gmdw_dpath and grid_maze_dfs_walker_top.
`default_nettype none

package gmdw_pkg;

   // Request actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // CSR port and register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COL  = 3'd5;

   // CSR reset values
   localparam logic [4:0] RST_ROWS_USED = 5'd11;
   localparam logic [5:0] RST_COLS_USED = 6'd30;
   localparam logic [3:0] RST_START_ROW = 4'd1;
   localparam logic [4:0] RST_START_COL = 5'd0;
   localparam logic [3:0] RST_GOAL_ROW  = 4'd2;
   localparam logic [4:0] RST_GOAL_COL  = 5'd29;

   // Neighbor directions, tried in this order; DIR_END means all tried
   localparam int DIR_W = 3;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

   // Width for bound compares; covers grids up to 64 rows or columns
   localparam int BND_W = 8;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  row_index;
      logic [31:0] row_bits;
   } req_type;

   typedef struct packed {
      logic [3:0] pos_row;
      logic [4:0] pos_col;
      logic       moved;
      logic       done_res;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_START    = 4'd2,
      OP_SKIP_DIR = 4'd3,
      OP_PROBE_RD = 4'd4,
      OP_MOVE     = 4'd5,
      OP_POP_RD   = 4'd6,
      OP_POP      = 4'd7,
      OP_REPORT   = 4'd8
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic expand_ok;
      logic dir_done;
      logic nb_in_bounds;
      logic can_enter;
   } dp_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_STEP  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_POP   = 4'b1000
   } ctrl_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/gmdw_ctrl.sv
// Walker sequencer: accepts items and steps the datapath through one tick.
// Depends on gmdw_pkg.
`default_nettype none

module gmdw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           action,
   input  wire gmdw_pkg::dp_stat_type stat,
   output gmdw_pkg::dp_cmd_type      cmd,
   output logic                      busy
);

   gmdw_pkg::ctrl_state_type state_ff, state_in;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = gmdw_pkg::OP_NONE;
      case (state_ff)
         gmdw_pkg::ST_IDLE: begin
            if (start) begin
               case (action)
                  gmdw_pkg::ACT_LOAD:  cmd.op = gmdw_pkg::OP_LOAD;
                  gmdw_pkg::ACT_START: cmd.op = gmdw_pkg::OP_START;
                  gmdw_pkg::ACT_TICK:  state_in = gmdw_pkg::ST_STEP;
                  default: ;
               endcase
            end
         end
         gmdw_pkg::ST_STEP: begin
            if (stat.stack_empty) begin
               cmd.op   = gmdw_pkg::OP_REPORT;
               state_in = gmdw_pkg::ST_IDLE;
            end else if (!stat.expand_ok || stat.dir_done) begin
               cmd.op   = gmdw_pkg::OP_POP_RD;
               state_in = gmdw_pkg::ST_POP;
            end else if (!stat.nb_in_bounds) begin
               cmd.op = gmdw_pkg::OP_SKIP_DIR;
            end else begin
               cmd.op   = gmdw_pkg::OP_PROBE_RD;
               state_in = gmdw_pkg::ST_CHECK;
            end
         end
         gmdw_pkg::ST_CHECK: begin
            if (stat.can_enter) begin
               cmd.op   = gmdw_pkg::OP_MOVE;
               state_in = gmdw_pkg::ST_IDLE;
            end else begin
               cmd.op   = gmdw_pkg::OP_SKIP_DIR;
               state_in = gmdw_pkg::ST_STEP;
            end
         end
         gmdw_pkg::ST_POP: begin
            cmd.op   = gmdw_pkg::OP_POP;
            state_in = gmdw_pkg::ST_IDLE;
         end
         default: state_in = gmdw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmdw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != gmdw_pkg::ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/gmdw_dpath.sv
// Walker datapath: CSRs, maze and visited memories, path stack, position.
// Depends on gmdw_pkg; driven by gmdw_ctrl commands.
`default_nettype none

module gmdw_dpath #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gmdw_pkg::dp_cmd_type            cmd,
   output gmdw_pkg::dp_stat_type                stat,
   input  wire gmdw_pkg::req_type               req_data,
   input  wire logic                            csr_valid,
   input  wire logic [gmdw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gmdw_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                                 rsp_valid,
   output gmdw_pkg::rsp_type                    rsp_data
);

   localparam int STACK_SIZE = MAX_ROWS * MAX_COLS;
   localparam int RAW = $clog2(MAX_ROWS);
   localparam int CAW = $clog2(MAX_COLS);
   localparam int CRW = (RAW > 4) ? RAW : 4;
   localparam int CCW = (CAW > 5) ? CAW : 5;
   localparam int SAW = $clog2(STACK_SIZE);
   localparam int SDW = $clog2(STACK_SIZE + 1);
   localparam int BW  = gmdw_pkg::BND_W;

   // CSRs
   logic [4:0] rows_used_ff;
   logic [5:0] cols_used_ff;
   logic [3:0] start_row_ff;
   logic [4:0] start_col_ff;
   logic [3:0] goal_row_ff;
   logic [4:0] goal_col_ff;

   // Walk state
   logic [SDW-1:0]            depth_ff, depth_in;
   logic [CRW-1:0]            cur_row_ff, cur_row_in;
   logic [CCW-1:0]            cur_col_ff, cur_col_in;
   logic [gmdw_pkg::DIR_W-1:0] dir_ff, dir_in;
   logic [MAX_ROWS-1:0]       vld_ff, vld_in;
   logic [RAW-1:0]            vis_row_ff, vis_row_in;
   logic [CAW-1:0]            nb_col_ff, nb_col_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   gmdw_pkg::rsp_type         rsp_ff, rsp_in;

   // Memories and their read registers
   logic [MAX_COLS-1:0] open_mem_ff [MAX_ROWS];
   logic [MAX_COLS-1:0] vis_mem_ff [MAX_ROWS];
   logic [1:0]          stk_mem_ff [STACK_SIZE];
   logic [MAX_COLS-1:0] open_rd_ff;
   logic [MAX_COLS-1:0] vis_rd_ff;
   logic [1:0]          stk_rd_ff;

   // Combinational helpers
   logic [BW-1:0]       eff_rows, eff_cols;
   logic [BW-1:0]       cur_r_w, cur_c_w, nr_w, nc_w;
   logic                nb_ok;
   logic [CRW-1:0]      start_row_w, ri_w;
   logic [CCW-1:0]      start_col_w;
   logic                start_inb, load_ok;
   logic [SDW-1:0]      depth_m1;
   logic [MAX_COLS-1:0] vis_eff;
   logic                vis_we;
   logic [RAW-1:0]      vis_waddr;
   logic [MAX_COLS-1:0] vis_wdata;
   logic [CRW-1:0]      pop_row;
   logic [CCW-1:0]      pop_col;

   // CSR writes; index beyond the register list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= gmdw_pkg::RST_ROWS_USED;
         cols_used_ff <= gmdw_pkg::RST_COLS_USED;
         start_row_ff <= gmdw_pkg::RST_START_ROW;
         start_col_ff <= gmdw_pkg::RST_START_COL;
         goal_row_ff  <= gmdw_pkg::RST_GOAL_ROW;
         goal_col_ff  <= gmdw_pkg::RST_GOAL_COL;
      end else if (csr_valid) begin
         case (csr_index)
            gmdw_pkg::CSR_ROWS_USED: rows_used_ff <= csr_data[4:0];
            gmdw_pkg::CSR_COLS_USED: cols_used_ff <= csr_data[5:0];
            gmdw_pkg::CSR_START_ROW: start_row_ff <= csr_data[3:0];
            gmdw_pkg::CSR_START_COL: start_col_ff <= csr_data[4:0];
            gmdw_pkg::CSR_GOAL_ROW:  goal_row_ff  <= csr_data[3:0];
            gmdw_pkg::CSR_GOAL_COL:  goal_col_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Bounds clamped to the grid size
   assign eff_rows = (BW'(rows_used_ff) > BW'(MAX_ROWS)) ? BW'(MAX_ROWS) : BW'(rows_used_ff);
   assign eff_cols = (BW'(cols_used_ff) > BW'(MAX_COLS)) ? BW'(MAX_COLS) : BW'(cols_used_ff);

   assign start_row_w = CRW'(start_row_ff);
   assign start_col_w = CCW'(start_col_ff);
   assign start_inb   = (BW'(start_row_ff) < eff_rows) && (BW'(start_col_ff) < eff_cols);
   assign ri_w        = CRW'(req_data.row_index);
   assign load_ok     = BW'(req_data.row_index) < BW'(MAX_ROWS);
   assign depth_m1    = depth_ff - SDW'(1);

   // Neighbor in the current direction
   always_comb begin
      cur_r_w = BW'(cur_row_ff);
      cur_c_w = BW'(cur_col_ff);
      nr_w    = cur_r_w;
      nc_w    = cur_c_w;
      nb_ok   = 1'b1;
      case (dir_ff)
         gmdw_pkg::DIR_RIGHT: nc_w = cur_c_w + BW'(1);
         gmdw_pkg::DIR_DOWN:  nr_w = cur_r_w + BW'(1);
         gmdw_pkg::DIR_LEFT: begin
            nc_w  = cur_c_w - BW'(1);
            nb_ok = (cur_col_ff != '0);
         end
         gmdw_pkg::DIR_UP: begin
            nr_w  = cur_r_w - BW'(1);
            nb_ok = (cur_row_ff != '0);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   // Visited row as read, zero when not written since start
   assign vis_eff = vld_ff[vis_row_ff] ? vis_rd_ff : '0;

   // Parent cell: step back against the direction that led here
   always_comb begin
      pop_row = cur_row_ff;
      pop_col = cur_col_ff;
      case ({1'b0, stk_rd_ff})
         gmdw_pkg::DIR_RIGHT: pop_col = cur_col_ff - CCW'(1);
         gmdw_pkg::DIR_DOWN:  pop_row = cur_row_ff - CRW'(1);
         gmdw_pkg::DIR_LEFT:  pop_col = cur_col_ff + CCW'(1);
         gmdw_pkg::DIR_UP:    pop_row = cur_row_ff + CRW'(1);
         default: ;
      endcase
   end

   // Status to the controller
   assign stat.stack_empty  = (depth_ff == '0);
   assign stat.expand_ok    = !((cur_row_ff == CRW'(goal_row_ff)) &&
                                (cur_col_ff == CCW'(goal_col_ff))) &&
                              (depth_ff < SDW'(STACK_SIZE));
   assign stat.dir_done     = (dir_ff == gmdw_pkg::DIR_END);
   assign stat.nb_in_bounds = nb_ok && (nr_w < eff_rows) && (nc_w < eff_cols);
   assign stat.can_enter    = open_rd_ff[nb_col_ff] & ~vis_eff[nb_col_ff];

   // Visited memory write port
   always_comb begin
      vis_we    = 1'b0;
      vis_waddr = vis_row_ff;
      vis_wdata = vis_eff;
      case (cmd.op)
         gmdw_pkg::OP_START: begin
            vis_we    = start_inb;
            vis_waddr = start_row_w[RAW-1:0];
            vis_wdata = MAX_COLS'(1) << start_col_w[CAW-1:0];
         end
         gmdw_pkg::OP_MOVE: begin
            vis_we    = 1'b1;
            vis_wdata = vis_eff | (MAX_COLS'(1) << nb_col_ff);
         end
         gmdw_pkg::OP_POP: begin
            vis_we    = 1'b1;
            vis_wdata = vis_eff & ~(MAX_COLS'(1) << cur_col_ff[CAW-1:0]);
         end
         default: ;
      endcase
   end

   // Walk state next values
   always_comb begin
      depth_in     = depth_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      dir_in       = dir_ff;
      vld_in       = vld_ff;
      vis_row_in   = vis_row_ff;
      nb_col_in    = nb_col_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = cmd.op inside {gmdw_pkg::OP_MOVE, gmdw_pkg::OP_POP, gmdw_pkg::OP_REPORT};
      case (cmd.op)
         gmdw_pkg::OP_START: begin
            vld_in = '0;
            if (start_inb) begin
               vld_in[start_row_w[RAW-1:0]] = 1'b1;
            end
            depth_in   = start_inb ? SDW'(1) : '0;
            cur_row_in = start_row_w;
            cur_col_in = start_col_w;
            dir_in     = gmdw_pkg::DIR_RIGHT;
         end
         gmdw_pkg::OP_SKIP_DIR: begin
            dir_in = dir_ff + gmdw_pkg::DIR_W'(1);
         end
         gmdw_pkg::OP_PROBE_RD: begin
            vis_row_in = nr_w[RAW-1:0];
            nb_col_in  = nc_w[CAW-1:0];
         end
         gmdw_pkg::OP_POP_RD: begin
            vis_row_in = cur_row_ff[RAW-1:0];
         end
         gmdw_pkg::OP_MOVE: begin
            vld_in[vis_row_ff] = 1'b1;
            cur_row_in      = CRW'(vis_row_ff);
            cur_col_in      = CCW'(nb_col_ff);
            depth_in        = depth_ff + SDW'(1);
            dir_in          = gmdw_pkg::DIR_RIGHT;
            rsp_in.pos_row  = cur_row_in[3:0];
            rsp_in.pos_col  = cur_col_in[4:0];
            rsp_in.moved    = 1'b1;
            rsp_in.done_res = 1'b0;
         end
         gmdw_pkg::OP_POP: begin
            vld_in[vis_row_ff] = 1'b1;
            depth_in = depth_m1;
            if (depth_m1 != '0) begin
               cur_row_in = pop_row;
               cur_col_in = pop_col;
               dir_in     = {1'b0, stk_rd_ff} + gmdw_pkg::DIR_W'(1);
            end else begin
               dir_in = gmdw_pkg::DIR_RIGHT;
            end
            rsp_in.pos_row  = cur_row_in[3:0];
            rsp_in.pos_col  = cur_col_in[4:0];
            rsp_in.moved    = 1'b0;
            rsp_in.done_res = (depth_m1 == '0);
         end
         gmdw_pkg::OP_REPORT: begin
            rsp_in.pos_row  = cur_row_ff[3:0];
            rsp_in.pos_col  = cur_col_ff[4:0];
            rsp_in.moved    = 1'b0;
            rsp_in.done_res = 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         dir_ff       <= gmdw_pkg::DIR_RIGHT;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         dir_ff       <= dir_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      vis_row_ff <= vis_row_in;
      nb_col_ff  <= nb_col_in;
      rsp_ff     <= rsp_in;
   end

   // Maze, visited and stack memories
   always_ff @(posedge clock) begin
      if ((cmd.op == gmdw_pkg::OP_LOAD) && load_ok) begin
         open_mem_ff[ri_w[RAW-1:0]] <= MAX_COLS'(req_data.row_bits);
      end
      if (vis_we) begin
         vis_mem_ff[vis_waddr] <= vis_wdata;
      end
      if (cmd.op == gmdw_pkg::OP_MOVE) begin
         stk_mem_ff[depth_ff[SAW-1:0]] <= dir_ff[1:0];
      end
      if (cmd.op == gmdw_pkg::OP_PROBE_RD) begin
         open_rd_ff <= open_mem_ff[nr_w[RAW-1:0]];
      end
      if ((cmd.op == gmdw_pkg::OP_PROBE_RD) || (cmd.op == gmdw_pkg::OP_POP_RD)) begin
         vis_rd_ff <= vis_mem_ff[vis_row_in];
      end
      if (cmd.op == gmdw_pkg::OP_POP_RD) begin
         stk_rd_ff <= stk_mem_ff[depth_m1[SAW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/grid_maze_dfs_walker_top.sv
// Grid maze depth-first walker, top level: sequencer plus datapath.
// Depends on gmdw_pkg, gmdw_ctrl and gmdw_dpath.
//
// Load and start items finish in the cycle they are accepted and give no
// result; start clears the visited map at once through per-row valid flags,
// so no clearing pass follows reset or start. A tick holds busy until its
// result is ready: a tick on an empty stack reports from the step state,
// each neighbor probed takes registered reads of the maze and visited rows
// and then the test, a neighbor off the grid is skipped without a read,
// and a backtrack takes stack and visited reads, then the write-back. The
// result of a tick shows on rsp_data for exactly one cycle with rsp_valid
// high, in the cycle busy falls; the receiver cannot stall it and must take
// it then. The CSR port is always ready and is meant to be written only
// while the block is idle.
`default_nettype none

module grid_maze_dfs_walker_top #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire gmdw_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   output gmdw_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gmdw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gmdw_pkg::CSR_DATA_W-1:0] csr_data
);

   gmdw_pkg::dp_cmd_type  cmd;
   gmdw_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   gmdw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   gmdw_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for grid_maze_dfs_walker_top: maze loads, walk starts and ticks.
// Holds a scoreboard class that predicts every walker report.
// Depends on gmdw_pkg and the walker RTL.
`timescale 1ns / 1ps

module tb_top;
   import gmdw_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 600;
   localparam int MAX_GAP       = 18;

   // action code the block must ignore
   localparam logic [1:0] ACT_NOOP = 2'd3;

   // Predicts the walker, holds the reports still due and checks each one
   class maze_walk_scoreboard;
      localparam int GRID_ROWS   = 16;
      localparam int GRID_COLS   = 32;
      localparam int TRAIL_CELLS = GRID_ROWS * GRID_COLS;

      logic [4:0]       rows_used;
      logic [5:0]       cols_used;
      logic [3:0]       start_row, goal_row;
      logic [4:0]       start_col, goal_col;

      logic [31:0]      open_rows [GRID_ROWS];
      logic [31:0]      visited_rows [GRID_ROWS];
      logic [3:0]       trail_row [TRAIL_CELLS];
      logic [4:0]       trail_col [TRAIL_CELLS];
      logic [1:0]       trail_dir [TRAIL_CELLS];
      int               trail_depth;
      logic [3:0]       walker_row;
      logic [4:0]       walker_col;
      logic [DIR_W-1:0] next_dir;

      rsp_type          reports_due [$];

      int ticks, moves, walks_finished, deepest, reg_writes, faults;

      function new();
         int r;
         rows_used  = RST_ROWS_USED;
         cols_used  = RST_COLS_USED;
         start_row  = RST_START_ROW;
         start_col  = RST_START_COL;
         goal_row   = RST_GOAL_ROW;
         goal_col   = RST_GOAL_COL;
         for (r = 0; r < GRID_ROWS; r++) begin
            open_rows[r]    = '0;
            visited_rows[r] = '0;
         end
         trail_depth = 0;
         walker_row  = '0;
         walker_col  = '0;
         next_dir    = DIR_RIGHT;
         ticks = 0; moves = 0; walks_finished = 0; deepest = 0;
         reg_writes = 0; faults = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ROWS_USED: rows_used = data[4:0];
            CSR_COLS_USED: cols_used = data;
            CSR_START_ROW: start_row = data[3:0];
            CSR_START_COL: start_col = data[4:0];
            CSR_GOAL_ROW:  goal_row  = data[3:0];
            CSR_GOAL_COL:  goal_col  = data[4:0];
            default: ;
         endcase
         reg_writes++;
      endfunction

      // bounds are clamped to the physical grid
      function int eff_rows();
         return (rows_used > GRID_ROWS) ? GRID_ROWS : int'(rows_used);
      endfunction

      function int eff_cols();
         return (cols_used > GRID_COLS) ? GRID_COLS : int'(cols_used);
      endfunction

      function bit inside_grid(int r, int c);
         return r >= 0 && c >= 0 && r < eff_rows() && c < eff_cols();
      endfunction

      // Apply one accepted item; a tick queues the report it must produce
      function void take_request(req_type item);
         rsp_type report;
         int      r, dd, found, to_row, to_col, nr, nc;
         bit      at_goal;
         case (item.action)
            ACT_LOAD: open_rows[item.row_index] = item.row_bits;
            ACT_START: begin
               for (r = 0; r < GRID_ROWS; r++) visited_rows[r] = '0;
               walker_row  = start_row;
               walker_col  = start_col;
               next_dir    = DIR_RIGHT;
               trail_depth = 0;
               if (inside_grid(int'(walker_row), int'(walker_col))) begin
                  visited_rows[walker_row][walker_col] = 1'b1;
                  trail_row[0] = walker_row;
                  trail_col[0] = walker_col;
                  trail_dir[0] = '0;
                  trail_depth  = 1;
               end
            end
            ACT_TICK: begin
               ticks++;
               report.moved = 1'b0;
               if (trail_depth > 0) begin
                  at_goal = (walker_row == goal_row) && (walker_col == goal_col);
                  found  = -1;
                  to_row = 0;
                  to_col = 0;
                  // resume the neighbor scan where the top cell left off
                  if (!at_goal && trail_depth < TRAIL_CELLS) begin
                     for (dd = int'(next_dir); dd < int'(DIR_END) && found < 0; dd++) begin
                        nr = int'(walker_row);
                        nc = int'(walker_col);
                        case (dd)
                           DIR_RIGHT: nc = nc + 1;
                           DIR_DOWN:  nr = nr + 1;
                           DIR_LEFT:  nc = nc - 1;
                           default:   nr = nr - 1;
                        endcase
                        if (inside_grid(nr, nc) && open_rows[nr][nc] &&
                            !visited_rows[nr][nc]) begin
                           found  = dd;
                           to_row = nr;
                           to_col = nc;
                        end
                     end
                  end
                  if (found >= 0) begin
                     // forward move: record direction, push the new cell
                     trail_dir[trail_depth-1] = 2'(found);
                     walker_row = 4'(to_row);
                     walker_col = 5'(to_col);
                     visited_rows[walker_row][walker_col] = 1'b1;
                     trail_row[trail_depth] = walker_row;
                     trail_col[trail_depth] = walker_col;
                     trail_dir[trail_depth] = '0;
                     trail_depth++;
                     next_dir     = DIR_RIGHT;
                     report.moved = 1'b1;
                     moves++;
                     if (trail_depth > deepest) deepest = trail_depth;
                  end else begin
                     // backtrack: unmark and pop; the last pop leaves the walker in place
                     visited_rows[walker_row][walker_col] = 1'b0;
                     trail_depth--;
                     if (trail_depth > 0) begin
                        walker_row = trail_row[trail_depth-1];
                        walker_col = trail_col[trail_depth-1];
                        next_dir   = {1'b0, trail_dir[trail_depth-1]} + 3'd1;
                     end else begin
                        next_dir = DIR_RIGHT;
                        walks_finished++;
                     end
                  end
               end
               report.pos_row  = walker_row;
               report.pos_col  = walker_col;
               report.done_res = (trail_depth == 0);
               reports_due.push_back(report);
            end
            default: ;
         endcase
      endfunction

      function void compare_report(rsp_type got);
         rsp_type want;
         if (reports_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: report with no tick pending: row=%0d col=%0d moved=%0b done=%0b",
                        $time, got.pos_row, got.pos_col, got.moved, got.done_res);
            return;
         end
         want = reports_due.pop_front();
         if (got.pos_row !== want.pos_row || got.pos_col !== want.pos_col ||
             got.moved !== want.moved || got.done_res !== want.done_res) begin
            faults++;
            if (faults <= 10)
               $display({"%0t: report mismatch: exp row=%0d col=%0d moved=%0b done=%0b, ",
                         "got row=%0d col=%0d moved=%0b done=%0b"},
                        $time, want.pos_row, want.pos_col, want.moved, want.done_res,
                        got.pos_row, got.pos_col, got.moved, got.done_res);
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   maze_walk_scoreboard sb;
   bit pace_on      = 1'b1;
   int items_sent   = 0;
   int quiet_cycles = 0;

   grid_maze_dfs_walker_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // result monitor: each strobe is taken at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.compare_report(rsp_data);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Present one item, with a random gap and now and then a full drain first
   task automatic send_item(input logic [1:0] action, input logic [3:0] idx,
                            input logic [31:0] bits);
      int      gap;
      bit      hold_off;
      req_type item;
      gap      = pace_on ? $urandom_range(0, MAX_GAP) : 0;
      hold_off = ($urandom_range(0, 39) == 0);
      if (hold_off && gap == 0) gap = 1;
      item.action    = action;
      item.row_index = idx;
      item.row_bits  = bits;
      if (gap > 0) begin
         start <= 1'b0;
         while (hold_off && sb.reports_due.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.take_request(item);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(ACT_TICK, 4'($urandom), $urandom);
   endtask

   // wait out every pending report, then the longest tick latency
   task automatic drain_reports();
      start <= 1'b0;
      while (sb.reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [5:0] rows, input logic [5:0] cols,
                           input logic [5:0] s_row, input logic [5:0] s_col,
                           input logic [5:0] g_row, input logic [5:0] g_col);
      drain_reports();
      write_csr(CSR_ROWS_USED, rows);
      write_csr(CSR_COLS_USED, cols);
      write_csr(CSR_START_ROW, s_row);
      write_csr(CSR_START_COL, s_col);
      write_csr(CSR_GOAL_ROW, g_row);
      write_csr(CSR_GOAL_COL, g_col);
   endtask

   // mode 0 sparse, 1 half open, 2 dense, 3 all open
   task automatic fill_maze(input int mode, input int nrows);
      int          r;
      logic [31:0] bits;
      for (r = 0; r < nrows; r++) begin
         case (mode)
            0:       bits = $urandom & $urandom;
            1:       bits = $urandom;
            2:       bits = $urandom | $urandom;
            default: bits = '1;
         endcase
         send_item(ACT_LOAD, 4'(r), bits);
      end
   endtask

   // tick until the walk is exhausted (or cap), then once more past done
   task automatic run_walk(input int cap);
      int n;
      n = 0;
      do begin
         send_tick();
         n++;
      end while (sb.trail_depth != 0 && n < cap);
      send_tick();
   endtask

   // mostly a cell inside the bounds, sometimes an edge or a value past the field
   function automatic logic [5:0] pick_coord(input int limit);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 6'h3F;
      if (roll == 1) return 6'($urandom_range(0, 63));
      if (roll == 2) return 6'd0;
      return 6'($urandom_range(0, (limit > 0) ? limit - 1 : 0));
   endfunction

   task automatic random_setting();
      logic [5:0] v;
      if ($urandom_range(0, 4) < 3) begin
         case ($urandom_range(0, 9))
            0:       v = 6'd0;
            1:       v = 6'd16;
            2:       v = 6'($urandom_range(0, 63));
            default: v = 6'($urandom_range(1, 5));
         endcase
         write_csr(CSR_ROWS_USED, v);
      end
      if ($urandom_range(0, 4) < 3) begin
         case ($urandom_range(0, 9))
            0:       v = 6'd0;
            1:       v = 6'd32;
            2:       v = 6'd63;
            3:       v = 6'($urandom_range(0, 63));
            default: v = 6'($urandom_range(1, 8));
         endcase
         write_csr(CSR_COLS_USED, v);
      end
      if ($urandom_range(0, 4) < 3) write_csr(CSR_START_ROW, pick_coord(sb.eff_rows()));
      if ($urandom_range(0, 4) < 3) write_csr(CSR_START_COL, pick_coord(sb.eff_cols()));
      if ($urandom_range(0, 4) < 3) write_csr(CSR_GOAL_ROW, pick_coord(sb.eff_rows()));
      if ($urandom_range(0, 4) < 3) write_csr(CSR_GOAL_COL, pick_coord(sb.eff_cols()));
      // unused register indexes must be ignored
      if ($urandom_range(0, 7) == 0)
         write_csr(CSR_IDX_W'($urandom_range(6, 7)), 6'($urandom));
   endtask

   // One random phase: maybe new settings and maze, then a run of mostly ticks
   task automatic random_phase();
      int n, k, pick;
      drain_reports();
      if ($urandom_range(0, 3) != 0) random_setting();
      pace_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 4) < 3) fill_maze($urandom_range(0, 3), sb.eff_rows());
      if ($urandom_range(0, 6) != 0) send_item(ACT_START, 4'($urandom), $urandom);
      n = $urandom_range(10, 80);
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 88)      send_tick();
         else if (pick < 93) send_item(ACT_LOAD, 4'($urandom), $urandom);
         else if (pick < 97) send_item(ACT_NOOP, 4'($urandom), $urandom);
         else                send_item(ACT_START, 4'($urandom), $urandom);
      end
   endtask

   initial begin
      int r;
      int target;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tick before any start, full maze load, ignored action, restart
      send_item(ACT_TICK, 4'hF, 32'hFFFF_FFFF);
      for (r = 0; r < 16; r++)
         send_item(ACT_LOAD, 4'(r), (r == 0) ? 32'hFFFF_FFFF :
                                    (r == 15) ? 32'h0 : ($urandom | $urandom));
      send_item(ACT_NOOP, 4'hF, 32'hFFFF_FFFF);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (4) send_tick();
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (2) send_tick();

      // zero bounds: nothing is in bounds, walk is done at once
      set_grid(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (2) send_tick();

      // bounds past the grid clamp; start in the far corner
      set_grid(6'd63, 6'd63, 6'd63, 6'd63, 6'd0, 6'd0);
      fill_maze(2, 16);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (30) send_tick();

      // start cell outside the bounds
      set_grid(6'd4, 6'd6, 6'd9, 6'd2, 6'd0, 6'd0);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (2) send_tick();

      // closed start cell, goal outside the bounds
      set_grid(6'd2, 6'd3, 6'd0, 6'd1, 6'd5, 6'd5);
      fill_maze(3, 2);
      send_item(ACT_LOAD, 4'd0, ~32'h2);
      send_item(ACT_START, 4'h0, 32'h0);
      run_walk(400);

      // goal next to the start cell is never expanded
      set_grid(6'd2, 6'd4, 6'd0, 6'd0, 6'd0, 6'd1);
      fill_maze(3, 2);
      send_item(ACT_START, 4'h0, 32'h0);
      run_walk(400);

      // settings change in the middle of a walk
      set_grid(6'd3, 6'd3, 6'd0, 6'd0, 6'd2, 6'd2);
      fill_maze(1, 3);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (6) send_tick();
      drain_reports();
      write_csr(CSR_GOAL_ROW, 6'd0);
      write_csr(CSR_ROWS_USED, 6'd2);
      run_walk(600);

      // exhaustive walk of an open 3x3 grid with the goal off the grid
      pace_on = 1'b0;
      set_grid(6'd3, 6'd3, 6'd0, 6'd0, 6'd15, 6'd31);
      fill_maze(3, 3);
      send_item(ACT_START, 4'h0, 32'h0);
      run_walk(2000);

      // open full grid: the path covers every cell and fills the stack
      set_grid(6'd16, 6'd32, 6'd0, 6'd0, 6'd1, 6'd0);
      fill_maze(3, 16);
      send_item(ACT_START, 4'h0, 32'h0);
      repeat (530) send_tick();
      pace_on = 1'b1;

      // random phases
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) random_phase();

      drain_reports();
      if (sb.reports_due.size() != 0) begin
         sb.faults++;
         $display("%0d reports never arrived", sb.reports_due.size());
      end
      $display({"Sent %0d items: %0d ticks, %0d forward moves, %0d walks exhausted, ",
                "deepest path %0d cells"},
               items_sent, sb.ticks, sb.moves, sb.walks_finished, sb.deepest);
      $display("%0d register writes across bounds, start and goal settings; %0d failed checks",
               sb.reg_writes, sb.faults);
      if (sb.faults == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
